FILE: rtl/core/rpj_pkg.sv
// Shared types, widths, register codes and arithmetic helpers of the reprojection unit.
`default_nettype none
package rpj_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 8;
	localparam int PRIN_W     = 20;
	localparam int SCALE_W    = 24;
	localparam int DISP_W     = 8;
	localparam int COLOR_W    = 8;
	localparam int OUT_W      = 32;
	localparam int IDX_W      = 3;
	localparam int CFG_DATA_W = 24;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam int COORD_FX_W = COORD_BITS + FRAC_BITS;
	localparam int DISP_FX_W  = DISP_W + FRAC_BITS;
	localparam int NUM_W      = (PRIN_W > COORD_FX_W) ? PRIN_W : COORD_FX_W;
	localparam int DEN_W      = ((PRIN_W > DISP_FX_W) ? PRIN_W : DISP_FX_W) + 1;
	localparam int PXY_W      = NUM_W + SCALE_W;
	localparam int PZ_W       = 2 * SCALE_W;
	localparam int DIV_W      = ((PXY_W > PZ_W) ? PXY_W : PZ_W) + 1;

	localparam int IN_DATA_W  = 2 * COORD_BITS + DISP_W + 3 * COLOR_W;
	localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = 3 * OUT_W + 3 * COLOR_W;
	localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

	typedef enum logic [IDX_W-1:0] {
		REG_PRINCIPAL_X       = 3'd0,
		REG_PRINCIPAL_X_RIGHT = 3'd1,
		REG_PRINCIPAL_Y       = 3'd2,
		REG_FOCAL_LENGTH      = 3'd3,
		REG_BASELINE          = 3'd4
	} reg_idx_t;

	typedef logic [DEN_W:0] den_ext_t;
	typedef logic [NUM_W:0] num_ext_t;
	typedef logic [DIV_W-1:0] div_t;

	typedef struct packed {
		logic [PRIN_W-1:0]  principal_x;
		logic [PRIN_W-1:0]  principal_x_right;
		logic [PRIN_W-1:0]  principal_y;
		logic [SCALE_W-1:0] focal_length;
		logic [SCALE_W-1:0] baseline;
	} cfg_t;

	typedef struct packed {
		logic               d_neg;
		logic [DEN_W-1:0]   d_mag;
		logic               nx_neg;
		logic [NUM_W-1:0]   nx_mag;
		logic               ny_neg;
		logic [NUM_W-1:0]   ny_mag;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} item_t;

	typedef struct packed {
		logic full;
		logic valid;
	} fifo_stat_t;

	typedef struct packed {
		logic               d_neg;
		logic               d_zero;
		logic               nx_neg;
		logic               nx_zero;
		logic               ny_neg;
		logic               ny_zero;
		logic               pz_zero;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} side_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] q;
	} lane_t;

	typedef struct packed {
		logic [OUT_W-1:0] val;
		logic             sat;
	} res_t;

	// One restoring division step: bring down the next dividend bit.
	function automatic lane_t div_step(input lane_t l, input logic [DEN_W-1:0] d);
		lane_t r;
		logic [DEN_W:0] t;
		logic qb;
		t = {l.rem, l.num[DIV_W-1]};
		qb = 1'b0;
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
			qb = 1'b1;
		end
		r.rem = t[DEN_W-1:0];
		r.num = {l.num[DIV_W-2:0], 1'b0};
		r.q = {l.q[DIV_W-2:0], qb};
		return r;
	endfunction

	// Applies signs, the zero-denominator rule and 32-bit saturation to a quotient.
	function automatic res_t finish(input logic [DIV_W-1:0] q, input logic n_neg,
			input logic n_zero, input logic d_neg, input logic d_zero);
		res_t r;
		logic big_neg;
		logic big_pos;
		big_neg = (q[DIV_W-1:OUT_W] != '0) || (q[OUT_W-1] && (q[OUT_W-2:0] != '0));
		big_pos = (q[DIV_W-1:OUT_W-1] != '0);
		r.sat = 1'b0;
		r.val = '0;
		if (d_zero) begin
			r.sat = 1'b1;
			if (!n_zero) begin
				r.val = n_neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
			end
		end else if (q == '0) begin
			r.val = '0;
		end else if (n_neg != d_neg) begin
			if (big_neg) begin
				r.sat = 1'b1;
				r.val = {1'b1, {(OUT_W-1){1'b0}}};
			end else begin
				r.val = (~q[OUT_W-1:0]) + 1'b1;
			end
		end else if (big_pos) begin
			r.sat = 1'b1;
			r.val = {1'b0, {(OUT_W-1){1'b1}}};
		end else begin
			r.val = q[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/disparity_to_point_reprojection_unit.sv
// Reprojection of disparity pixels to colored 3-D points: top level.
// Pixels enter as beats on the s_ channel and points leave as beats on the m_ channel.
// A pixel with zero disparity is taken but yields no point; every other pixel yields one.
// Camera parameters are written through the cfg_ channel, which is always ready; they
// should only change while no pixel is in flight.
// Throughput is one pixel per cycle while the output is not stalled. An accepted beat is
// written into the queue, then passes the multiplier register, the register that adds the
// rounding bias, the restoring divider (DIV_W stages, one quotient bit each), and the
// output register, into which it is saturated.
// When a point waits at the output and m_tready is low, the whole arithmetic pipeline
// freezes; the four-beat queue in front takes pixels until full, then s_tready drops.
// Reset clears the queue and every stage's valid bit, and loads the default calibration.
// The saturated flag travels in m_tuser.
`default_nettype none
module disparity_to_point_reprojection_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// pixel_row, pixel_col, disparity, blue_in, green_in, red_in
	input  wire logic [rpj_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// pos_x, pos_y, pos_z, red_out, green_out, blue_out
	output logic [rpj_pkg::OUT_TDATA_W-1:0]        m_tdata,
	// saturated
	output logic                                   m_tuser,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rpj_pkg::IDX_W-1:0]         cfg_index,
	input  wire logic [rpj_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CB = rpj_pkg::COORD_BITS;
	localparam int CW = rpj_pkg::COLOR_W;
	localparam int DW = rpj_pkg::DISP_W;
	localparam int OW = rpj_pkg::OUT_W;

	rpj_pkg::cfg_t       cfg;
	rpj_pkg::item_t      wr_item;
	rpj_pkg::item_t      rd_item;
	rpj_pkg::fifo_stat_t stat;
	logic                push;
	logic                pop;
	logic [OW-1:0]       pos_x;
	logic [OW-1:0]       pos_y;
	logic [OW-1:0]       pos_z;
	logic [CW-1:0]       red_out;
	logic [CW-1:0]       green_out;
	logic [CW-1:0]       blue_out;

	assign cfg_ready = 1'b1;
	assign s_tready = !stat.full;

	rpj_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_idx  (cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	rpj_front u_front (
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.pixel_row (s_tdata[CB-1:0]),
		.pixel_col (s_tdata[2*CB-1:CB]),
		.disparity (s_tdata[2*CB+DW-1:2*CB]),
		.blue_in   (s_tdata[2*CB+DW+CW-1:2*CB+DW]),
		.green_in  (s_tdata[2*CB+DW+2*CW-1:2*CB+DW+CW]),
		.red_in    (s_tdata[2*CB+DW+3*CW-1:2*CB+DW+2*CW]),
		.cfg       (cfg),
		.push      (push),
		.item      (wr_item)
	);

	rpj_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.stat    (stat)
	);

	rpj_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.stat      (stat),
		.item      (rd_item),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.saturated (m_tuser)
	);

	assign m_tdata = rpj_pkg::OUT_TDATA_W'({blue_out, green_out, red_out, pos_z, pos_y, pos_x});

`ifndef NO_ASSERTIONS
	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> stat.valid)
		else $error("queue read while empty");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !push)
		else $error("queue written while full");

	a_zero_disp_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tdata[2*CB+DW-1:2*CB] == '0)) |-> !push)
		else $error("pixel without a match was queued");

	a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !pop)
		else $error("pipeline advanced while output stalled");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/rpj_cfg.sv
// Configuration register file of the reprojection unit.
`default_nettype none
module rpj_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [rpj_pkg::IDX_W-1:0]      wr_idx,
	input  wire logic [rpj_pkg::CFG_DATA_W-1:0] wr_data,
	output rpj_pkg::cfg_t                       cfg
);

	rpj_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.principal_x       <= 20'd322666;
			cfg_q.principal_x_right <= 20'd328959;
			cfg_q.principal_y       <= 20'd134676;
			cfg_q.focal_length      <= 24'd640191;
			cfg_q.baseline          <= 24'd123722;
		end else if (wr_en) begin
			unique case (rpj_pkg::reg_idx_t'(wr_idx))
				rpj_pkg::REG_PRINCIPAL_X: begin
					cfg_q.principal_x <= wr_data[rpj_pkg::PRIN_W-1:0];
				end
				rpj_pkg::REG_PRINCIPAL_X_RIGHT: begin
					cfg_q.principal_x_right <= wr_data[rpj_pkg::PRIN_W-1:0];
				end
				rpj_pkg::REG_PRINCIPAL_Y: begin
					cfg_q.principal_y <= wr_data[rpj_pkg::PRIN_W-1:0];
				end
				rpj_pkg::REG_FOCAL_LENGTH: begin
					cfg_q.focal_length <= wr_data[rpj_pkg::SCALE_W-1:0];
				end
				rpj_pkg::REG_BASELINE: begin
					cfg_q.baseline <= wr_data[rpj_pkg::SCALE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: rtl/core/rpj_front.sv
// Front end: drops pixels without a match and forms signed offsets and the denominator.
`default_nettype none
module rpj_front (
	input  wire logic                            in_valid,
	input  wire logic                            in_ready,
	input  wire logic [rpj_pkg::COORD_BITS-1:0]  pixel_row,
	input  wire logic [rpj_pkg::COORD_BITS-1:0]  pixel_col,
	input  wire logic [rpj_pkg::DISP_W-1:0]      disparity,
	input  wire logic [rpj_pkg::COLOR_W-1:0]     blue_in,
	input  wire logic [rpj_pkg::COLOR_W-1:0]     green_in,
	input  wire logic [rpj_pkg::COLOR_W-1:0]     red_in,
	input  rpj_pkg::cfg_t                        cfg,
	output logic                                 push,
	output rpj_pkg::item_t                       item
);

	rpj_pkg::den_ext_t den;
	rpj_pkg::num_ext_t nx;
	rpj_pkg::num_ext_t ny;

	always_comb begin
		den = rpj_pkg::den_ext_t'(cfg.principal_x) - rpj_pkg::den_ext_t'(cfg.principal_x_right)
			- rpj_pkg::den_ext_t'({disparity, {rpj_pkg::FRAC_BITS{1'b0}}});
		nx = rpj_pkg::num_ext_t'(cfg.principal_x)
			- rpj_pkg::num_ext_t'({pixel_col, {rpj_pkg::FRAC_BITS{1'b0}}});
		ny = rpj_pkg::num_ext_t'({pixel_row, {rpj_pkg::FRAC_BITS{1'b0}}})
			- rpj_pkg::num_ext_t'(cfg.principal_y);
		item.d_neg = den[rpj_pkg::DEN_W];
		item.d_mag = den[rpj_pkg::DEN_W] ? rpj_pkg::DEN_W'(-den) : den[rpj_pkg::DEN_W-1:0];
		item.nx_neg = nx[rpj_pkg::NUM_W];
		item.nx_mag = nx[rpj_pkg::NUM_W] ? rpj_pkg::NUM_W'(-nx) : nx[rpj_pkg::NUM_W-1:0];
		item.ny_neg = ny[rpj_pkg::NUM_W];
		item.ny_mag = ny[rpj_pkg::NUM_W] ? rpj_pkg::NUM_W'(-ny) : ny[rpj_pkg::NUM_W-1:0];
		item.red = red_in;
		item.green = green_in;
		item.blue = blue_in;
	end

	// A pixel without a match is taken from the stream but never queued.
	assign push = in_valid && in_ready && (disparity != '0);

endmodule
`default_nettype wire

FILE: rtl/core/rpj_fifo.sv
// Short show-ahead queue between the front end and the arithmetic pipeline.
`default_nettype none
module rpj_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  rpj_pkg::item_t        wr_item,
	input  wire logic             pop,
	output rpj_pkg::item_t        rd_item,
	output rpj_pkg::fifo_stat_t   stat
);

	rpj_pkg::item_t mem [0:rpj_pkg::FIFO_DEPTH-1];
	logic [rpj_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [rpj_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [rpj_pkg::FIFO_AW:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_item = mem[rd_ptr_q];
	assign stat.full = (count_q == (rpj_pkg::FIFO_AW+1)'(rpj_pkg::FIFO_DEPTH));
	assign stat.valid = (count_q != '0);

endmodule
`default_nettype wire

FILE: rtl/core/rpj_back.sv
// Back end: multiplies, divides one quotient bit per stage, saturates and holds the result.
`default_nettype none
module rpj_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  rpj_pkg::cfg_t                   cfg,
	input  rpj_pkg::fifo_stat_t             stat,
	input  rpj_pkg::item_t                  item,
	output logic                            pop,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [rpj_pkg::OUT_W-1:0]       pos_x,
	output logic [rpj_pkg::OUT_W-1:0]       pos_y,
	output logic [rpj_pkg::OUT_W-1:0]       pos_z,
	output logic [rpj_pkg::COLOR_W-1:0]     red_out,
	output logic [rpj_pkg::COLOR_W-1:0]     green_out,
	output logic [rpj_pkg::COLOR_W-1:0]     blue_out,
	output logic                            saturated
);

	localparam int N = rpj_pkg::DIV_W;

	logic                          adv;
	logic                          vld_s1;
	rpj_pkg::item_t                item_s1;
	logic [rpj_pkg::PXY_W-1:0]     px_s1;
	logic [rpj_pkg::PXY_W-1:0]     py_s1;
	logic [rpj_pkg::PZ_W-1:0]      pz_s1;

	logic                          div_vld_s  [0:N];
	rpj_pkg::lane_t                div_x_s    [0:N];
	rpj_pkg::lane_t                div_y_s    [0:N];
	rpj_pkg::lane_t                div_z_s    [0:N];
	logic [rpj_pkg::DEN_W-1:0]     div_den_s  [0:N];
	rpj_pkg::side_t                div_side_s [0:N];

	logic                          out_vld_q;
	rpj_pkg::res_t                 res_x_q;
	rpj_pkg::res_t                 res_y_q;
	rpj_pkg::res_t                 res_z_q;
	rpj_pkg::side_t                side_q;

	// The whole pipeline moves together; it halts only when a held result is not taken.
	assign adv = !out_vld_q || out_ready;
	assign pop = adv && stat.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item;
			px_s1 <= item.nx_mag * cfg.baseline;
			py_s1 <= item.ny_mag * cfg.baseline;
			pz_s1 <= cfg.focal_length * cfg.baseline;
		end
	end

	// Adding half the divisor turns the truncating division into round half away from zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s[0] <= 1'b0;
		end else if (adv) begin
			div_vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_x_s[0].rem <= '0;
			div_x_s[0].q <= '0;
			div_x_s[0].num <= rpj_pkg::div_t'(px_s1) + rpj_pkg::div_t'(item_s1.d_mag >> 1);
			div_y_s[0].rem <= '0;
			div_y_s[0].q <= '0;
			div_y_s[0].num <= rpj_pkg::div_t'(py_s1) + rpj_pkg::div_t'(item_s1.d_mag >> 1);
			div_z_s[0].rem <= '0;
			div_z_s[0].q <= '0;
			div_z_s[0].num <= rpj_pkg::div_t'(pz_s1) + rpj_pkg::div_t'(item_s1.d_mag >> 1);
			div_den_s[0] <= item_s1.d_mag;
			div_side_s[0].d_neg <= item_s1.d_neg;
			div_side_s[0].d_zero <= (item_s1.d_mag == '0);
			div_side_s[0].nx_neg <= item_s1.nx_neg;
			div_side_s[0].nx_zero <= (px_s1 == '0);
			div_side_s[0].ny_neg <= item_s1.ny_neg;
			div_side_s[0].ny_zero <= (py_s1 == '0);
			div_side_s[0].pz_zero <= (pz_s1 == '0);
			div_side_s[0].red <= item_s1.red;
			div_side_s[0].green <= item_s1.green;
			div_side_s[0].blue <= item_s1.blue;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				div_vld_s[k+1] <= div_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_x_s[k+1] <= rpj_pkg::div_step(div_x_s[k], div_den_s[k]);
				div_y_s[k+1] <= rpj_pkg::div_step(div_y_s[k], div_den_s[k]);
				div_z_s[k+1] <= rpj_pkg::div_step(div_z_s[k], div_den_s[k]);
				div_den_s[k+1] <= div_den_s[k];
				div_side_s[k+1] <= div_side_s[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= div_vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_x_q <= rpj_pkg::finish(div_x_s[N].q, div_side_s[N].nx_neg,
				div_side_s[N].nx_zero, div_side_s[N].d_neg, div_side_s[N].d_zero);
			res_y_q <= rpj_pkg::finish(div_y_s[N].q, div_side_s[N].ny_neg,
				div_side_s[N].ny_zero, div_side_s[N].d_neg, div_side_s[N].d_zero);
			res_z_q <= rpj_pkg::finish(div_z_s[N].q, 1'b0,
				div_side_s[N].pz_zero, div_side_s[N].d_neg, div_side_s[N].d_zero);
			side_q <= div_side_s[N];
		end
	end

	assign out_valid = out_vld_q;
	assign pos_x = res_x_q.val;
	assign pos_y = res_y_q.val;
	assign pos_z = res_z_q.val;
	assign red_out = side_q.red;
	assign green_out = side_q.green;
	assign blue_out = side_q.blue;
	assign saturated = res_x_q.sat || res_y_q.sat || res_z_q.sat;

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench of the disparity-to-point reprojection unit.
`timescale 1ns / 1ps
module tb;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        saturated;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [rpj_pkg::IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [rpj_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rpj_pkg::IDX_W-1:0] cfg_index = '0;
	logic [rpj_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Calibration as the block should hold it.
	logic [19:0] cal_px, cal_pxr, cal_py;
	logic [23:0] cal_focal, cal_base;

	logic [rpj_pkg::IN_TDATA_W-1:0] pending_pixels[$];
	point_t expected_points[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;
	int errors = 0;
	int cycles = 0;
	logic pixel_taken = 1'b0;

	disparity_to_point_reprojection_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Rounded signed quotient of two magnitudes, clamped to 32 bits.
	function automatic logic [31:0] rounded_quotient(input bit nneg, input logic [63:0] nmag,
			input bit dneg, input logic [63:0] dmag, inout bit sat);
		logic [63:0] q;
		if (dmag == 0) begin
			sat = 1'b1;
			if (nmag == 0) return 32'h0;
			return nneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		q = (nmag + dmag / 2) / dmag;
		if (q == 0) return 32'h0;
		if (nneg != dneg) begin
			if (q > 64'h8000_0000) begin
				sat = 1'b1;
				return 32'h8000_0000;
			end
			return 32'h0 - q[31:0];
		end
		if (q > 64'h7FFF_FFFF) begin
			sat = 1'b1;
			return 32'h7FFF_FFFF;
		end
		return q[31:0];
	endfunction

	function automatic point_t reproject(input logic [rpj_pkg::IN_TDATA_W-1:0] px);
		point_t p;
		longint den, nx, ny;
		bit sat;
		sat = 1'b0;
		den = longint'(cal_px) - longint'(cal_pxr)
			- (longint'(px[31:24]) << rpj_pkg::FRAC_BITS);
		nx = longint'(cal_px) - (longint'(px[23:12]) << rpj_pkg::FRAC_BITS);
		ny = (longint'(px[11:0]) << rpj_pkg::FRAC_BITS) - longint'(cal_py);
		p.pos_x = rounded_quotient(nx < 0, (nx < 0 ? -nx : nx) * cal_base, den < 0,
			den < 0 ? -den : den, sat);
		p.pos_y = rounded_quotient(ny < 0, (ny < 0 ? -ny : ny) * cal_base, den < 0,
			den < 0 ? -den : den, sat);
		p.pos_z = rounded_quotient(1'b0, 64'(cal_focal) * cal_base, den < 0,
			den < 0 ? -den : den, sat);
		p.red = px[55:48];
		p.green = px[47:40];
		p.blue = px[39:32];
		p.saturated = sat;
		return p;
	endfunction

	function automatic logic [rpj_pkg::IN_TDATA_W-1:0] pack_pixel(input int row, input int col,
			input int disp, input int b, input int g, input int r);
		return {r[7:0], g[7:0], b[7:0], disp[7:0], col[11:0], row[11:0]};
	endfunction

	function automatic void add_pixel(input logic [rpj_pkg::IN_TDATA_W-1:0] p);
		pending_pixels = {pending_pixels, p};
	endfunction

	// Sampling side: prediction at input beats, checking at output beats.
	always @(posedge clk) begin
		point_t exp_p;
		point_t got;
		cycles <= cycles + 1;
		pixel_taken <= s_tvalid && s_tready;
		if (s_tvalid && s_tready && s_tdata[31:24] != 0)
			expected_points = {expected_points, reproject(s_tdata)};
		if (m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[103:96],
				m_tdata[111:104], m_tdata[119:112], m_tuser};
			if (expected_points.size() == 0) begin
				$error("point beat with no pixel pending: %h", m_tdata);
				errors++;
			end else begin
				exp_p = expected_points.pop_front();
				if (got.pos_x !== exp_p.pos_x) begin
					$error("pos_x expected %h got %h", exp_p.pos_x, got.pos_x); errors++;
				end
				if (got.pos_y !== exp_p.pos_y) begin
					$error("pos_y expected %h got %h", exp_p.pos_y, got.pos_y); errors++;
				end
				if (got.pos_z !== exp_p.pos_z) begin
					$error("pos_z expected %h got %h", exp_p.pos_z, got.pos_z); errors++;
				end
				if (got.red !== exp_p.red) begin
					$error("red_out expected %h got %h", exp_p.red, got.red); errors++;
				end
				if (got.green !== exp_p.green) begin
					$error("green_out expected %h got %h", exp_p.green, got.green); errors++;
				end
				if (got.blue !== exp_p.blue) begin
					$error("blue_out expected %h got %h", exp_p.blue, got.blue); errors++;
				end
				if (got.saturated !== exp_p.saturated) begin
					$error("saturated expected %b got %b", exp_p.saturated, got.saturated);
					errors++;
				end
			end
		end
	end

	// Pixel driver: a beat offered stays up until it is taken.
	always @(negedge clk) begin
		if (pixel_taken) void'(pending_pixels.pop_front());
		if (s_tvalid && !pixel_taken) begin
			// hold the current beat
		end else if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
			s_tvalid <= 1'b1;
			s_tdata <= pending_pixels[0];
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Point receiver, with an optional long hold-off.
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (cycles > 400000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(input rpj_pkg::reg_idx_t idx, input logic [23:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rpj_pkg::REG_PRINCIPAL_X:       cal_px = val[19:0];
			rpj_pkg::REG_PRINCIPAL_X_RIGHT: cal_pxr = val[19:0];
			rpj_pkg::REG_PRINCIPAL_Y:       cal_py = val[19:0];
			rpj_pkg::REG_FOCAL_LENGTH:      cal_focal = val;
			rpj_pkg::REG_BASELINE:          cal_base = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain;
		while (pending_pixels.size() > 0 || s_tvalid || expected_points.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic add_random(input int n);
		int d;
		repeat (n) begin
			d = ($urandom_range(9) == 0) ? 0 : $urandom_range(255);
			add_pixel(pack_pixel($urandom_range(4095), $urandom_range(4095), d,
				$urandom_range(255), $urandom_range(255), $urandom_range(255)));
		end
	endtask

	initial begin
		cal_px = 20'd322666;
		cal_pxr = 20'd328959;
		cal_py = 20'd134676;
		cal_focal = 24'd640191;
		cal_base = 24'd123722;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pixels on the reset calibration: extremes, no-match and colors.
		add_pixel(pack_pixel(0, 0, 1, 0, 0, 0));
		add_pixel(pack_pixel(4095, 4095, 255, 255, 255, 255));
		add_pixel(pack_pixel(0, 4095, 0, 1, 2, 3));
		add_pixel(pack_pixel(526, 1260, 24, 170, 85, 170));
		add_pixel(pack_pixel(4095, 0, 128, 85, 170, 85));
		add_pixel(pack_pixel(2048, 2048, 2, 16, 32, 64));
		drain();

		// Zero denominator at disparity 5, plus numerators that are zero.
		write_reg(rpj_pkg::REG_PRINCIPAL_X, 24'h010500);
		write_reg(rpj_pkg::REG_PRINCIPAL_X_RIGHT, 24'h010000);
		write_reg(rpj_pkg::REG_PRINCIPAL_Y, 24'h000300);
		add_pixel(pack_pixel(3, 261, 5, 1, 1, 1));
		add_pixel(pack_pixel(0, 4095, 5, 2, 2, 2));
		add_pixel(pack_pixel(4095, 0, 5, 3, 3, 3));
		add_pixel(pack_pixel(3, 261, 6, 4, 4, 4));
		add_pixel(pack_pixel(3, 261, 4, 5, 5, 5));
		drain();

		// Largest scale factors with extreme principal points, then smallest ones.
		write_reg(rpj_pkg::REG_FOCAL_LENGTH, 24'hFFFFFF);
		write_reg(rpj_pkg::REG_BASELINE, 24'hFFFFFF);
		write_reg(rpj_pkg::REG_PRINCIPAL_X, 24'hFFFFFF);
		write_reg(rpj_pkg::REG_PRINCIPAL_X_RIGHT, 24'h000000);
		write_reg(rpj_pkg::REG_PRINCIPAL_Y, 24'hFFFFFF);
		write_reg(rpj_pkg::reg_idx_t'(3'd7), 24'h123456);
		add_pixel(pack_pixel(0, 0, 255, 9, 9, 9));
		add_pixel(pack_pixel(4095, 4095, 1, 8, 8, 8));
		add_pixel(pack_pixel(4095, 4095, 255, 7, 7, 7));
		drain();
		write_reg(rpj_pkg::REG_PRINCIPAL_X, 24'h000000);
		write_reg(rpj_pkg::REG_PRINCIPAL_X_RIGHT, 24'h0FFFFF);
		write_reg(rpj_pkg::REG_PRINCIPAL_Y, 24'h000000);
		write_reg(rpj_pkg::REG_FOCAL_LENGTH, 24'h000001);
		write_reg(rpj_pkg::REG_BASELINE, 24'h000001);
		add_pixel(pack_pixel(4095, 4095, 255, 6, 6, 6));
		add_pixel(pack_pixel(1, 1, 1, 5, 5, 5));
		drain();

		// Random phases, each with its own calibration and idle pattern.
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(rpj_pkg::REG_PRINCIPAL_X, 24'($urandom_range(20'hFFFFF)));
			write_reg(rpj_pkg::REG_PRINCIPAL_X_RIGHT, 24'($urandom_range(20'hFFFFF)));
			write_reg(rpj_pkg::REG_PRINCIPAL_Y, 24'($urandom_range(20'hFFFFF)));
			write_reg(rpj_pkg::REG_FOCAL_LENGTH, 24'($urandom_range(24'hFFFFFF, 1)));
			write_reg(rpj_pkg::REG_BASELINE, (ph % 2) ? 24'($urandom_range(24'hFFFFFF, 1))
				: 24'($urandom_range(24'h3FFFF, 1)));
			if (ph == 1) begin
				// Nominal camera: disparities near the rig's center give sane depths.
				write_reg(rpj_pkg::REG_PRINCIPAL_X, 24'd322666);
				write_reg(rpj_pkg::REG_PRINCIPAL_X_RIGHT, 24'd328959);
			end
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			if (ph == 4) hold_req = 300;
			add_random(72);
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

FILE: files.f
rtl/core/rpj_pkg.sv
rtl/core/rpj_cfg.sv
rtl/core/rpj_front.sv
rtl/core/rpj_fifo.sv
rtl/core/rpj_back.sv
rtl/core/disparity_to_point_reprojection_unit.sv
tb/sv/tb.sv
